// ===== sv/wvma_pkg.sv =====
// Shared types and constants for the window variance motion alarm.
`default_nettype none

package wvma_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int THR_W      = 8;
    localparam int MODE_W     = 2;
    localparam int DIST_W     = 16;
    localparam int MEAN_W     = 16;
    localparam int VAR_W      = 33;
    localparam int DIGIT_BITS = 8;

    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_DIST_EN    = 2'd1;
    localparam logic [1:0] REG_VIB_EN     = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;
    localparam logic             DIST_EN_RESET   = 1'b1;
    localparam logic             VIB_EN_RESET    = 1'b1;

    localparam logic [MODE_W-1:0] MODE_DISTANCE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VIBRATION = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;

    localparam logic SRC_DISTANCE  = 1'b0;
    localparam logic SRC_VIBRATION = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0] variance_threshold;
        logic             distance_enable;
        logic             vibration_enable;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/wvma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wvma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/wvma_cfg.sv =====
// APB configuration registers: variance threshold and sensing enables.
`default_nettype none

module wvma_cfg
    import wvma_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD: cfg_next.variance_threshold = pwdata[THR_W-1:0];
                REG_DIST_EN:   cfg_next.distance_enable    = pwdata[0];
                REG_VIB_EN:    cfg_next.vibration_enable   = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.variance_threshold);
            REG_DIST_EN:   prdata = APB_DATA_W'(cfg_reg.distance_enable);
            REG_VIB_EN:    prdata = APB_DATA_W'(cfg_reg.vibration_enable);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.variance_threshold <= THRESHOLD_RESET;
            cfg_reg.distance_enable    <= DIST_EN_RESET;
            cfg_reg.vibration_enable   <= VIB_EN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wvma_div.sv =====
// Serial restoring divider by a small divisor, eight quotient bits per cycle.
`default_nettype none

module wvma_div
    import wvma_pkg::*;
#(
    parameter int DIV_W = 40,
    parameter int REM_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [REM_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);

    localparam int STEPS  = DIV_W / DIGIT_BITS;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [DIV_W-1:0]  quo_reg, quo_next, quo_t;
    logic [REM_W-1:0]  rem_reg, rem_next, rem_t;
    logic [REM_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [REM_W:0]    trial;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        rem_t = rem_reg;
        quo_t = quo_reg;
        trial = '0;
        for (int k = 0; k < DIGIT_BITS; k++) begin
            trial = {rem_t, quo_t[DIV_W-1]};
            quo_t = {quo_t[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_t    = REM_W'(trial - {1'b0, dsr_reg});
                quo_t[0] = 1'b1;
            end else begin
                rem_t = trial[REM_W-1:0];
            end
        end
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = quo_t;
            rem_next  = rem_t;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

`default_nettype wire

// ===== sv/window_variance_motion_alarm.sv =====
// Window variance motion alarm: top level with sample memory, passes and alarm latch.
//
// The block keeps the last WINDOW distance samples in a small circular RAM and a
// latched alarm. Per request it writes the sample (mode 0), sweeps the RAM once to
// form the sum and check for empty or zero entries, divides by WINDOW, sweeps again
// to accumulate squared deviations through a registered multiplier, and divides by
// WINDOW-1. The result is presented in the output register, and the next request is
// taken after it is presented. The two passes share the single read port, and both
// divisions use the shared divider, which retires eight quotient bits per cycle.
// One request is in flight at a time; a new one is taken while the previous result
// waits in the output register, and its result waits until that one is taken.
// Window entries start as zero through per-entry valid bits, so no clearing pass
// follows reset.
`default_nettype none

module window_variance_motion_alarm
    import wvma_pkg::*;
#(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [MODE_W-1:0]     s_mode,
    input  wire logic [DIST_W-1:0]     s_distance_value,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_alarm_active,
    output logic                       m_alarm_raised,
    output logic                       m_raise_source,
    output logic      [MEAN_W-1:0]     m_window_mean,
    output logic      [VAR_W-1:0]      m_window_variance,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SB      = SAMPLE_BITS;
    localparam int AW      = $clog2(WINDOW);
    localparam int CW      = $clog2(WINDOW + 1);
    localparam int SUM_W   = SB + CW;
    localparam int SQ_W    = 2 * SB;
    localparam int ACC_RAW = SQ_W + CW;
    localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;
    localparam int DIV_W   = ((ACC_W + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_VAR  = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    cfg_t cfg;

    logic [2:0]        state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              p1_reg, p1_next;
    logic              p2_reg, p2_next;
    logic              p3_reg, p3_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              all_nz_reg, all_nz_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SB-1:0]     avg_reg, avg_next;
    logic [SB-1:0]     d_reg, d_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W:0]    acc_sum;
    logic              alarm_reg, alarm_next;

    logic              m_valid_reg, m_valid_next;
    logic              raised_reg, raised_next;
    logic              src_reg, src_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [VAR_W-1:0]  var_reg, var_next;

    logic              accept;
    logic              ram_we;
    logic [SB-1:0]     ram_rdata;
    logic [SB-1:0]     rd_val;
    logic              in_pass;
    logic              issue;
    logic              pass_end;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [CW-1:0]     div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic              var_gt;

    wvma_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wvma_ram #(
        .WIDTH (SB),
        .DEPTH (WINDOW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (SB'(s_distance_value)),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    wvma_div #(
        .DIV_W (DIV_W),
        .REM_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid & s_ready;
    assign ram_we  = accept & (s_mode == MODE_DISTANCE);

    assign in_pass  = (state_reg == S_SUM) || (state_reg == S_VAR);
    assign issue    = in_pass && (cnt_reg != CW'(WINDOW));
    assign pass_end = in_pass && (cnt_reg == CW'(WINDOW)) && !p1_reg && !p2_reg && !p3_reg;
    assign rd_val   = rd_vld_reg ? ram_rdata : '0;
    assign acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(sq_reg);

    assign div_start    = pass_end;
    assign div_dividend = (state_reg == S_SUM) ? DIV_W'(sum_reg) : DIV_W'(acc_reg);
    assign div_divisor  = (state_reg == S_SUM) ? CW'(WINDOW) : CW'(WINDOW - 1);
    assign var_gt       = div_quo > DIV_W'(cfg.variance_threshold);

    assign m_valid           = m_valid_reg;
    assign m_alarm_active    = alarm_reg;
    assign m_alarm_raised    = raised_reg;
    assign m_raise_source    = src_reg;
    assign m_window_mean     = mean_reg;
    assign m_window_variance = var_reg;

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        head_next    = head_reg;
        valid_next   = valid_reg;
        cnt_next     = issue ? cnt_reg + CW'(1) : cnt_reg;
        p1_next      = issue;
        p2_next      = p1_reg && (state_reg == S_VAR);
        p3_next      = p2_reg;
        rd_vld_next  = issue && valid_reg[cnt_reg[AW-1:0]];
        all_nz_next  = all_nz_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        d_next       = d_reg;
        sq_next      = d_reg * d_reg;
        acc_next     = acc_reg;
        alarm_next   = alarm_reg;
        m_valid_next = m_valid_reg && !m_ready;
        raised_next  = raised_reg;
        src_next     = src_reg;
        mean_next    = mean_reg;
        var_next     = var_reg;

        if (p1_reg && (state_reg == S_SUM)) begin
            sum_next    = sum_reg + SUM_W'(rd_val);
            all_nz_next = all_nz_reg && (rd_val != '0);
        end
        if (p1_reg && (state_reg == S_VAR)) begin
            d_next = (rd_val >= avg_reg) ? rd_val - avg_reg : avg_reg - rd_val;
        end
        if (p3_reg) begin
            acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next   = s_mode;
                    sum_next    = '0;
                    acc_next    = '0;
                    all_nz_next = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_SUM;
                    if (ram_we) begin
                        valid_next[head_reg] = 1'b1;
                        head_next = (head_reg == AW'(WINDOW - 1)) ? '0 : head_reg + AW'(1);
                    end
                end
            end
            S_SUM: begin
                if (pass_end) begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    avg_next   = SB'(div_quo);
                    cnt_next   = '0;
                    state_next = S_VAR;
                end
            end
            S_VAR: begin
                if (pass_end) begin
                    state_next = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    raised_next  = 1'b0;
                    src_next     = SRC_DISTANCE;
                    mean_next    = ((DIV_W'(avg_reg) >> MEAN_W) != '0) ? '1 : MEAN_W'(avg_reg);
                    var_next     = ((div_quo >> VAR_W) != '0) ? '1 : VAR_W'(div_quo);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    case (mode_reg)
                        MODE_DISTANCE: begin
                            if (!alarm_reg && all_nz_reg && var_gt && cfg.distance_enable) begin
                                alarm_next  = 1'b1;
                                raised_next = 1'b1;
                            end
                        end
                        MODE_VIBRATION: begin
                            if (!alarm_reg && cfg.vibration_enable) begin
                                alarm_next  = 1'b1;
                                raised_next = 1'b1;
                                src_next    = SRC_VIBRATION;
                            end
                        end
                        MODE_CLEAR: begin
                            alarm_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            p3_reg      <= 1'b0;
            alarm_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            p3_reg      <= p3_next;
            alarm_reg   <= alarm_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg   <= mode_next;
        rd_vld_reg <= rd_vld_next;
        all_nz_reg <= all_nz_next;
        sum_reg    <= sum_next;
        avg_reg    <= avg_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        acc_reg    <= acc_next;
        raised_reg <= raised_next;
        src_reg    <= src_next;
        mean_reg   <= mean_next;
        var_reg    <= var_next;
    end

endmodule

`default_nettype wire
